>>> src/tcf_pkg.sv
// tcf_pkg: shared constants, register indexes and the CORDIC arctangent table
// for the tilt complementary filter. No dependencies.
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CNT_W        = 5;
    localparam int MUL_W        = 76;   // shift-add accumulator width
    localparam int MPL_W        = 17;   // multiplier bits, one per cycle
    localparam int SUM_W        = 32;   // x^2 + z^2
    localparam int ROOT_W       = 24;
    localparam int CX_W         = 28;
    localparam int Z_W          = 26;
    localparam int DIV_W        = 55;
    localparam int DIV_CNT_W    = 6;
    localparam int REM_W        = 10;
    localparam int Divisor      = 1000;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_LIMIT  = 23040;

    localparam logic [2:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_ALPHA        = 3'd1;
    localparam logic [2:0] CFG_GYRO_SCALE   = 3'd2;
    localparam logic [2:0] CFG_RAMP_ON      = 3'd3;
    localparam logic [2:0] CFG_RAMP_OFF     = 3'd4;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/tilt_complementary_filter.sv
// tilt_complementary_filter: sequencer, state and output register of the filter.
// Depends on tcf_pkg, tcf_mul, tcf_sqrt, tcf_cordic, tcf_div.
// An item that applies no update goes straight to the output step; an update runs the
// bit-serial units in turn (two squaring multiplies, root, CORDIC). The seeding update ends
// there, while a later update goes on (two gyro multiplies, divide, two blend multiplies);
// both then pass the latch and output steps. A new request is taken only in idle, after the
// current item has left; the result register lets the next request in while it waits.
// Synchronous active-low reset restores register defaults and clears the angle.
module tilt_complementary_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic signed [15:0]  i_gyro_x,
    input  logic        [15:0]  i_elapsed_ms,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_tilt_angle,
    output logic                o_on_ramp,
    output logic                o_updated,
    input  logic                i_cfg_we,
    input  logic        [2:0]   i_cfg_idx,
    input  logic        [15:0]  i_cfg_data
);
    import tcf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SQX   = 12'b0000_0000_0010,
        S_SQZ   = 12'b0000_0000_0100,
        S_SQRT  = 12'b0000_0000_1000,
        S_CORD  = 12'b0000_0001_0000,
        S_GS    = 12'b0000_0010_0000,
        S_GD    = 12'b0000_0100_0000,
        S_DIV   = 12'b0000_1000_0000,
        S_BL1   = 12'b0001_0000_0000,
        S_BL2   = 12'b0010_0000_0000,
        S_LATCH = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;

    logic [9:0]  r_min_interval;
    logic [15:0] r_alpha;
    logic [15:0] r_gyro_scale;
    logic [14:0] r_ramp_on;
    logic [14:0] r_ramp_off;

    logic signed [ANGLE_W-1:0] r_angle;
    logic signed [ANGLE_W-1:0] r_pitch;
    logic        r_seeded;
    logic        r_latch;
    logic [15:0] r_time_accum;
    logic [15:0] r_dt;
    logic        r_upd;
    logic        r_launched;

    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic signed [15:0] r_gx;

    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_angle;
    logic                      r_out_ramp;
    logic                      r_out_upd;

    // unit controls
    logic                    mul_start, mul_done;
    logic signed [MUL_W-1:0] mul_mcand, mul_acc0, mul_acc;
    logic [MPL_W-1:0]        mul_mplier;
    logic                    sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]       root;
    logic                    cord_start, cord_done;
    logic signed [ANGLE_W-1:0] cord_pitch;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        quot;

    logic [16:0]             accum_sum;
    logic [15:0]             accum_sat;
    logic [15:0]             mag_ax, mag_az, mag_gx;
    logic signed [MUL_W-1:0] pred;
    logic signed [MUL_W-1:0] quot_ext;
    logic signed [MUL_W-1:0] blend_rnd;
    logic signed [43:0]      blend_r;
    logic [ANGLE_W-1:0]      angle_mag;
    logic                    accept;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 16'(~e + 17'd1) : v;
    endfunction

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign accum_sum = {1'b0, r_time_accum} + {1'b0, i_elapsed_ms};
    assign accum_sat = accum_sum[16] ? 16'hFFFF : accum_sum[15:0];
    assign mag_ax    = abs16(r_ax);
    assign mag_az    = abs16(r_az);
    assign mag_gx    = abs16(r_gx);

    // predicted angle, 16 fractional bits; gyro term carries the sign of -gyro_x
    assign quot_ext  = MUL_W'(quot);
    assign pred      = (MUL_W'(r_angle) <<< 16) + (r_gx[15] ? quot_ext : -quot_ext);
    assign blend_rnd = mul_acc + (MUL_W'(1) <<< 31);
    assign blend_r   = blend_rnd[MUL_W-1:32];
    assign angle_mag = r_angle[ANGLE_W-1] ? ANGLE_W'(-r_angle) : r_angle;

    assign mul_start  = !r_launched && ((r_state == S_SQX) || (r_state == S_SQZ) ||
                        (r_state == S_GS) || (r_state == S_GD) ||
                        (r_state == S_BL1) || (r_state == S_BL2));
    assign sqrt_start = !r_launched && (r_state == S_SQRT);
    assign cord_start = !r_launched && (r_state == S_CORD);
    assign div_start  = !r_launched && (r_state == S_DIV);

    always_comb begin
        mul_mcand  = '0;
        mul_mplier = '0;
        mul_acc0   = '0;
        unique case (r_state)
            S_SQX: begin
                mul_mcand  = MUL_W'(mag_ax);
                mul_mplier = MPL_W'(mag_ax);
            end
            S_SQZ: begin
                mul_mcand  = MUL_W'(mag_az);
                mul_mplier = MPL_W'(mag_az);
                mul_acc0   = mul_acc;
            end
            S_GS: begin
                mul_mcand  = MUL_W'(mag_gx);
                mul_mplier = MPL_W'(r_gyro_scale);
            end
            S_GD: begin
                mul_mcand  = mul_acc;
                mul_mplier = MPL_W'(r_dt);
            end
            S_BL1: begin
                mul_mcand  = pred;
                mul_mplier = MPL_W'(r_alpha);
            end
            S_BL2: begin
                mul_mcand  = MUL_W'(r_pitch) <<< 16;
                mul_mplier = 17'h10000 - MPL_W'(r_alpha);
                mul_acc0   = mul_acc;
            end
            default: begin
                mul_mcand  = '0;
            end
        endcase
    end

    tcf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .i_acc    (mul_acc0),
        .o_done   (mul_done),
        .o_acc    (mul_acc)
    );

    tcf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (mul_acc[SUM_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    tcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_cx    (root),
        .i_ay    (r_ay),
        .o_done  (cord_done),
        .o_pitch (cord_pitch)
    );

    tcf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({mul_acc[DIV_W-8:0], 7'b0}),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= 10'd10;
            r_alpha        <= 16'd64225;
            r_gyro_scale   <= 16'd500;
            r_ramp_on      <= 15'd1024;
            r_ramp_off     <= 15'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[9:0];
                CFG_ALPHA:        r_alpha        <= i_cfg_data;
                CFG_GYRO_SCALE:   r_gyro_scale   <= i_cfg_data;
                CFG_RAMP_ON:      r_ramp_on      <= i_cfg_data[14:0];
                CFG_RAMP_OFF:     r_ramp_off     <= i_cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_angle      <= '0;
            r_pitch      <= '0;
            r_seeded     <= 1'b0;
            r_latch      <= 1'b0;
            r_time_accum <= '0;
            r_dt         <= '0;
            r_upd        <= 1'b0;
            r_launched   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_angle  <= '0;
            r_out_ramp   <= 1'b0;
            r_out_upd    <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE)) r_out_valid <= 1'b0;
            if (mul_start || sqrt_start || cord_start || div_start) r_launched <= 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (accum_sat >= 16'(r_min_interval)) begin
                            r_dt         <= accum_sat;
                            r_time_accum <= '0;
                            r_upd        <= 1'b1;
                            r_state      <= S_SQX;
                        end else begin
                            r_time_accum <= accum_sat;
                            r_upd        <= 1'b0;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_SQX: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_SQZ;
                    end
                end
                S_SQZ: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (cord_done) begin
                        r_launched <= 1'b0;
                        r_pitch    <= cord_pitch;
                        if (!r_seeded) begin
                            r_angle  <= cord_pitch;
                            r_seeded <= 1'b1;
                            r_state  <= S_LATCH;
                        end else begin
                            r_state  <= S_GS;
                        end
                    end
                end
                S_GS: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_GD;
                    end
                end
                S_GD: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_BL1;
                    end
                end
                S_BL1: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        r_state    <= S_BL2;
                    end
                end
                S_BL2: begin
                    if (mul_done) begin
                        r_launched <= 1'b0;
                        if (blend_r > 44'sd23040)
                            r_angle <= 16'sd23040;
                        else if (blend_r < -44'sd23040)
                            r_angle <= -16'sd23040;
                        else
                            r_angle <= blend_r[ANGLE_W-1:0];
                        r_state <= S_LATCH;
                    end
                end
                S_LATCH: begin
                    if (!r_latch && (angle_mag >= 16'(r_ramp_on)))
                        r_latch <= 1'b1;
                    else if (r_latch && (angle_mag <= 16'(r_ramp_off)))
                        r_latch <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_angle <= r_angle;
                        r_out_ramp  <= r_latch;
                        r_out_upd   <= r_upd;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tilt_angle = r_out_angle;
    assign o_on_ramp    = r_out_ramp;
    assign o_updated    = r_out_upd;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("request accepted while another was in flight");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_angle <= 16'sd23040) && (r_angle >= -16'sd23040))
        else $error("angle beyond saturation limit");

    a_accum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_upd) |-> (r_time_accum == '0))
        else $error("time accumulator not cleared by update");

    a_seeded_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GS) |-> r_seeded)
        else $error("gyro path entered before seeding");
endmodule

>>> src/tcf_mul.sv
// tcf_mul: shift-add multiplier, one multiplier bit per cycle, with preload
// of the accumulator. Depends on tcf_pkg.
module tcf_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tcf_pkg::MUL_W-1:0]   i_mcand,
    input  logic        [tcf_pkg::MPL_W-1:0]   i_mplier,
    input  logic signed [tcf_pkg::MUL_W-1:0]   i_acc,
    output logic                               o_done,
    output logic signed [tcf_pkg::MUL_W-1:0]   o_acc
);
    import tcf_pkg::*;

    logic signed [MUL_W-1:0] r_m;
    logic signed [MUL_W-1:0] r_acc;
    logic        [MPL_W-1:0] r_b;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MPL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_mcand;
            r_b   <= i_mplier;
            r_acc <= i_acc;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_m;
            r_m <= r_m <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

>>> src/tcf_sqrt.sv
// tcf_sqrt: digit-by-digit integer square root of (x^2+z^2) << 16,
// one result bit per cycle. Depends on tcf_pkg.
module tcf_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcf_pkg::SUM_W-1:0]    i_val,
    output logic                         o_done,
    output logic [tcf_pkg::ROOT_W-1:0]   o_root
);
    import tcf_pkg::*;

    logic [2*ROOT_W-1:0] r_rad;
    logic [ROOT_W+2:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [ROOT_W+2:0]   t_rem;
    logic [ROOT_W+2:0]   trial;

    assign t_rem = {r_rem[ROOT_W:0], r_rad[2*ROOT_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_val, 16'h0000};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (t_rem >= trial) begin
                r_rem  <= t_rem - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= t_rem;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> src/tcf_cordic.sv
// tcf_cordic: vectoring CORDIC, one micro-rotation per cycle, giving the
// accelerometer pitch in 1/128 degree. Depends on tcf_pkg.
module tcf_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic        [tcf_pkg::ROOT_W-1:0]   i_cx,
    input  logic signed [15:0]                  i_ay,
    output logic                                o_done,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  o_pitch
);
    import tcf_pkg::*;

    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [CNT_W-1:0]       r_i;
    logic                   r_zero;
    logic                   r_busy;
    logic                   r_done;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [Z_W-1:0]  z_rnd;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CNT_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CX_W'(i_cx);
            r_y    <= -(CX_W'(i_ay) <<< 8);
            r_z    <= '0;
            r_zero <= (i_cx == '0) && (i_ay == '0);
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_q16(r_i);
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_q16(r_i);
            end
        end
    end

    // 2^-16 degree to 1/128 degree, round half up
    assign z_rnd   = (r_z + Z_W'(256)) >>> 9;
    assign o_pitch = r_zero ? '0 : z_rnd[ANGLE_W-1:0];
    assign o_done  = r_done;
endmodule

>>> src/tcf_div.sv
// tcf_div: restoring division by the constant 1000, one quotient bit per
// cycle. Depends on tcf_pkg.
module tcf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcf_pkg::DIV_W-1:0]   i_dividend,
    output logic                        o_done,
    output logic [tcf_pkg::DIV_W-1:0]   o_quot
);
    import tcf_pkg::*;

    logic [DIV_W-1:0]     r_q;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [REM_W:0]       t_rem;

    assign t_rem = {r_rem, r_q[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            if (t_rem >= (REM_W+1)'(Divisor)) begin
                r_rem <= REM_W'(t_rem - (REM_W+1)'(Divisor));
                r_q   <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= t_rem[REM_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> dv/tcf_checker.sv
`timescale 1ns / 100ps
// tcf_checker: watches the request, result and register ports of the tilt filter,
// predicts each result and compares it. Depends on tcf_pkg.
module tcf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic        [15:0] i_elapsed_ms,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_tilt_angle,
    input  logic               i_on_ramp,
    input  logic               i_updated,
    input  logic               i_cfg_we,
    input  logic        [2:0]  i_cfg_idx,
    input  logic        [15:0] i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    import tcf_pkg::*;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic               on_ramp;
        logic               updated;
    } t_tilt_result;

    t_tilt_result tilt_q[$];

    logic [9:0]  min_interval;
    logic [15:0] alpha;
    logic [15:0] gyro_scale;
    logic [14:0] ramp_on;
    logic [14:0] ramp_off;

    logic signed [15:0] angle;
    logic               seeded;
    logic               latch;
    logic [15:0]        time_accum;

    int fails;

    assign o_pending    = tilt_q.size();
    assign o_fail_count = fails;

    function automatic longint atan_step(int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // pitch in 1/128 degree from the three accelerometer axes
    function automatic longint pitch_from_accel(longint ax, longint ay, longint az);
        longint cx, cy, z, dx, dy;
        cx = int_sqrt((ax * ax + az * az) <<< 16);
        cy = -ay * 256;
        z  = 0;
        if (cx == 0 && cy == 0) return 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx; cy -= dy; z += atan_step(i);
            end else begin
                cx -= dx; cy += dy; z -= atan_step(i);
            end
        end
        return (z + 256) >>> 9;
    endfunction

    task automatic predict_tilt(longint ax, longint ay, longint az, longint gx,
                                longint el);
        t_tilt_result r;
        longint acc, pitch, num, pred, a, sum, nxt, mag;
        r.updated = 1'b0;
        acc = longint'(time_accum) + el;
        if (acc > 65535) acc = 65535;
        time_accum = acc[15:0];
        if (acc >= longint'(min_interval)) begin
            pitch = pitch_from_accel(ax, ay, az);
            time_accum = '0;
            r.updated = 1'b1;
            if (!seeded) begin
                angle  = pitch[15:0];
                seeded = 1'b1;
            end else begin
                num  = -gx * longint'(gyro_scale) * acc * 128;
                pred = longint'(angle) * 65536 + num / 1000;
                a    = longint'(alpha);
                sum  = a * pred + (65536 - a) * (pitch * 65536);
                nxt  = (sum + (64'sd1 <<< 31)) >>> 32;
                if (nxt > ANGLE_LIMIT) nxt = ANGLE_LIMIT;
                if (nxt < -ANGLE_LIMIT) nxt = -ANGLE_LIMIT;
                angle = nxt[15:0];
            end
            mag = (angle < 0) ? -longint'(angle) : longint'(angle);
            if (!latch && mag >= longint'(ramp_on)) latch = 1'b1;
            else if (latch && mag <= longint'(ramp_off)) latch = 1'b0;
        end
        r.tilt_angle = angle;
        r.on_ramp    = latch;
        tilt_q.push_back(r);
    endtask

    task automatic report_mismatch(string what);
        $display("tcf_checker: mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_tilt_result want;
        if (!i_rst_n) begin
            min_interval = 10'd10;
            alpha        = 16'd64225;
            gyro_scale   = 16'd500;
            ramp_on      = 15'd1024;
            ramp_off     = 15'd640;
            angle        = '0;
            seeded       = 1'b0;
            latch        = 1'b0;
            time_accum   = '0;
            tilt_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_INTERVAL: min_interval = i_cfg_data[9:0];
                    CFG_ALPHA:        alpha        = i_cfg_data;
                    CFG_GYRO_SCALE:   gyro_scale   = i_cfg_data;
                    CFG_RAMP_ON:      ramp_on      = i_cfg_data[14:0];
                    CFG_RAMP_OFF:     ramp_off     = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (tilt_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = tilt_q.pop_front();
                    if (i_tilt_angle !== want.tilt_angle)
                        report_mismatch($sformatf("tilt_angle %0d, expected %0d",
                                                  i_tilt_angle, want.tilt_angle));
                    if (i_on_ramp !== want.on_ramp)
                        report_mismatch($sformatf("on_ramp %b, expected %b",
                                                  i_on_ramp, want.on_ramp));
                    if (i_updated !== want.updated)
                        report_mismatch($sformatf("updated %b, expected %b",
                                                  i_updated, want.updated));
                end
            end
            if (i_valid && i_in_ready)
                predict_tilt(longint'(i_accel_x), longint'(i_accel_y),
                             longint'(i_accel_z), longint'(i_gyro_x),
                             longint'(i_elapsed_ms));
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus, register writes and verdict for tilt_complementary_filter.
// Depends on tcf_pkg, tcf_checker and the filter RTL.
module tb;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, gyro_x = '0;
    logic        [15:0] elapsed_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] tilt_angle;
    logic               on_ramp, updated;
    logic               cfg_we = 1'b0;
    logic        [2:0]  cfg_idx = '0;
    logic        [15:0] cfg_data = '0;

    int  pending, fail_count;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    logic hold_go = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 0;
    longint cycles = 0;

    always #6 i_clk = ~i_clk;

    tilt_complementary_filter dut (
        .i_clk, .i_rst_n,
        .i_valid(in_valid), .o_ready(in_ready),
        .i_accel_x(accel_x), .i_accel_y(accel_y), .i_accel_z(accel_z),
        .i_gyro_x(gyro_x), .i_elapsed_ms(elapsed_ms),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_tilt_angle(tilt_angle), .o_on_ramp(on_ramp), .o_updated(updated),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tcf_checker chk (
        .i_clk, .i_rst_n,
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_accel_x(accel_x), .i_accel_y(accel_y), .i_accel_z(accel_z),
        .i_gyro_x(gyro_x), .i_elapsed_ms(elapsed_ms),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_tilt_angle(tilt_angle), .i_on_ramp(on_ramp), .i_updated(updated),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left = 3000;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** tilt_complementary_filter: FAILED **");
            $finish;
        end
    end

    // called right after a posedge; returns at the edge the request is taken
    task automatic send_req(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                            logic [15:0] gx, logic [15:0] el);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        accel_x    <= ax;
        accel_y    <= ay;
        accel_z    <= az;
        gyro_x     <= gx;
        elapsed_ms <= el;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_reqs(int n, int max_el);
        logic [15:0] ax, ay, az, el;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                // plausible motion: moderate axes, short intervals
                ax = 16'($signed($urandom_range(0, 32000)) - 16000);
                ay = 16'($signed($urandom_range(0, 32000)) - 16000);
                az = 16'($signed($urandom_range(0, 32000)) - 16000);
                el = 16'($urandom_range(0, max_el));
            end else begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
                el = 16'($urandom);
            end
            send_req(ax, ay, az, 16'($urandom), el);
        end
    endtask

    task automatic set_regs(logic [15:0] mi, logic [15:0] al, logic [15:0] gs,
                            logic [15:0] ron, logic [15:0] roff);
        wait_idle();
        write_reg(CFG_MIN_INTERVAL, mi);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_GYRO_SCALE, gs);
        write_reg(CFG_RAMP_ON, ron);
        write_reg(CFG_RAMP_OFF, roff);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: no update, then seeding update, then extremes
        send_req(16'd100, 16'd200, 16'd16384, 16'd0, 16'd5);
        send_req(16'd100, 16'd200, 16'd16384, 16'd0, 16'd5);
        send_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_req(16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'd10);   // zero vector
        send_req(16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'd20);   // straight down
        send_req(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 16'd20);   // straight up
        send_req(16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'd9);

        // large elapsed times, up to the 16-bit maximum
        set_regs(16'd1000, 16'd65535, 16'd65535, 16'd0, 16'd0);
        send_req(16'd0, 16'h4000, 16'd0, 16'h8000, 16'd40000);
        send_req(16'd0, 16'h4000, 16'd0, 16'h8000, 16'd40000);
        send_req(16'd0, 16'h4000, 16'd0, 16'h7FFF, 16'hFFFF);
        send_req(16'd0, 16'h4000, 16'd0, 16'h7FFF, 16'd999);

        // every item updates; crossed thresholds; out-of-range register values
        set_regs(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
        send_req(16'd5, 16'h8000, 16'd7, 16'd0, 16'd0);
        send_req(16'd5, 16'h7FFF, 16'd7, 16'd0, 16'd0);
        set_regs(16'hFFFF, 16'd32768, 16'd65535, 16'd2000, 16'd6000);
        send_req(16'd0, 16'h7000, 16'd0, 16'h8000, 16'd1023);
        send_req(16'd0, 16'h7000, 16'd0, 16'h8000, 16'd2000);
        send_req(16'd0, 16'hA000, 16'd0, 16'd0, 16'd1023);

        // random phases across settings and idling modes
        set_regs(16'd10, 16'd64225, 16'd500, 16'd1024, 16'd640);
        random_reqs(260, 20);
        set_regs(16'd0, 16'd60000, 16'd4000, 16'd23040, 16'd0);
        send_idle_pct = 65;
        random_reqs(260, 3);
        set_regs(16'd3, 16'd0, 16'd65535, 16'd0, 16'd23040);
        send_idle_pct = 0; recv_stall_pct = 65;
        random_reqs(130, 8);
        hold_go <= 1'b1;
        random_reqs(130, 8);
        set_regs(16'd1, 16'd65535, 16'd100, 16'd500, 16'd400);
        send_idle_pct = 31; recv_stall_pct = 31;
        random_reqs(260, 4);
        set_regs(16'd25, 16'd50000, 16'd1000, 16'd3000, 16'd2500);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_reqs(260, 12);

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("** tilt_complementary_filter: PASSED **");
        else
            $display("** tilt_complementary_filter: FAILED **");
        $finish;
    end

endmodule
